>>> rtl/cenc_pkg.sv
// Shared constants and types for the word-packed convolutional encoder.
package cenc_pkg;

  // Code structure.
  localparam int CONSTRAINT_LENGTH = 7;
  localparam int OUTPUTS_PER_BIT   = 2;
  localparam int WORD_BITS         = 16;

  // Derived widths.
  localparam int HIST_W   = CONSTRAINT_LENGTH - 1;
  localparam int EXT_W    = WORD_BITS + HIST_W;
  localparam int STREAM_W = WORD_BITS * OUTPUTS_PER_BIT;
  localparam int CNT_W    = $clog2(OUTPUTS_PER_BIT);
  localparam int NUM_POLY = 3;

  // Configuration port.
  localparam int POLY_W   = 15;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 4;

  localparam logic [POLY_W-1:0] POLY0_RST = POLY_W'(61);
  localparam logic [POLY_W-1:0] POLY1_RST = POLY_W'(79);
  localparam logic [POLY_W-1:0] POLY2_RST = POLY_W'(109);

  // Index of the last code word of one data word.
  localparam logic [CNT_W-1:0] LAST_WORD = CNT_W'(OUTPUTS_PER_BIT - 1);

  // Register indexes, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_POLY0 = 2'd0,
    REG_POLY1 = 2'd1,
    REG_POLY2 = 2'd2
  } reg_idx_t;

  typedef logic [POLY_W-1:0] poly_t;

endpackage

>>> rtl/convolutional_encoder_word_packed_top.sv
// Rate 1/N convolutional encoder with 16-bit word-packed input and output beats.
// Pipeline: a data beat is held in the input register, then encoded into the result stage,
//   from which its code words are offered one per output beat.
// Throughput: the output channel carries one 16-bit code word per beat; the next data word
//   loads into the result stage only when the last code word of the current one is taken.
// Reset: rst_n is synchronous, active low; it clears the bit history to zero, empties
//   both stages and restores the generator polynomials to their reset values.
module convolutional_encoder_word_packed_top (
  input  logic                        clk,
  input  logic                        rst_n,
  // Input stream
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [15:0]                 in_tdata,   // [15:0] data_word
  input  logic                        in_tuser,   // [0] restart
  // Result stream
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [15:0]                 out_tdata,  // [15:0] code_word
  output logic                        out_tlast,  // last_of_word
  // Configuration port
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [cenc_pkg::APB_AW-1:0] cfg_paddr,
  input  logic [cenc_pkg::APB_DW-1:0] cfg_pwdata,
  output logic [cenc_pkg::APB_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);

  // Input register stage.
  logic                              in_valid_r;
  logic [cenc_pkg::WORD_BITS-1:0]    in_data_r;
  logic                              in_restart_r;

  // Encoder state and result stage.
  logic [cenc_pkg::HIST_W-1:0]       hist_r, hist_nxt;
  logic                              res_valid_r;
  logic [cenc_pkg::STREAM_W-1:0]     res_r, res_nxt;
  logic [cenc_pkg::CNT_W-1:0]        cnt_r;

  // Generator polynomials.
  cenc_pkg::poly_t                   poly_r [cenc_pkg::NUM_POLY];
  cenc_pkg::reg_idx_t                cfg_idx;
  logic                              cfg_wr;

  logic                              out_take;
  logic                              out_done;
  logic                              load;

  // Handshake control.
  assign out_take  = res_valid_r && out_tready;
  assign out_done  = out_take && (cnt_r == cenc_pkg::LAST_WORD);
  assign load      = in_valid_r && (!res_valid_r || out_done);
  assign in_tready = !in_valid_r || load;

  // Input register: refills whenever its item moves on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
    if (in_tvalid && in_tready) begin
      in_data_r    <= in_tdata;
      in_restart_r <= in_tuser;
    end
  end

  // Encode all sixteen message bits at once. The extended sequence holds the
  // earlier message bits below the new ones, so the window for message bit i
  // is a fixed slice of it.
  always_comb begin
    logic [cenc_pkg::EXT_W-1:0]             ext;
    logic [cenc_pkg::HIST_W-1:0]            hist_base;
    logic [cenc_pkg::CONSTRAINT_LENGTH-1:0] win;
    hist_base = in_restart_r ? '0 : hist_r;
    for (int m = 0; m < cenc_pkg::HIST_W; m++) begin
      ext[cenc_pkg::HIST_W-1-m] = hist_base[m];
    end
    for (int t = 0; t < cenc_pkg::WORD_BITS; t++) begin
      ext[cenc_pkg::HIST_W+t] = in_data_r[t];
    end
    res_nxt = '0;
    for (int i = 0; i < cenc_pkg::WORD_BITS; i++) begin
      for (int j = 0; j < cenc_pkg::CONSTRAINT_LENGTH; j++) begin
        win[j] = ext[cenc_pkg::HIST_W+i-j];
      end
      for (int c = 0; c < cenc_pkg::OUTPUTS_PER_BIT; c++) begin
        res_nxt[i*cenc_pkg::OUTPUTS_PER_BIT+c] =
          ^(win & poly_r[c][cenc_pkg::CONSTRAINT_LENGTH-1:0]);
      end
    end
    for (int j = 0; j < cenc_pkg::HIST_W; j++) begin
      hist_nxt[j] = ext[cenc_pkg::HIST_W+cenc_pkg::WORD_BITS-1-j];
    end
  end

  // Result stage: holds the packed code words and shifts one out per beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
      cnt_r       <= '0;
      hist_r      <= '0;
    end else if (load) begin
      res_valid_r <= 1'b1;
      cnt_r       <= '0;
      hist_r      <= hist_nxt;
    end else if (out_done) begin
      res_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else if (out_take) begin
      cnt_r <= cnt_r + 1'b1;
    end
    if (load) begin
      res_r <= res_nxt;
    end else if (out_take) begin
      res_r <= res_r >> cenc_pkg::WORD_BITS;
    end
  end

  assign out_tvalid = res_valid_r;
  assign out_tdata  = res_r[cenc_pkg::WORD_BITS-1:0];
  assign out_tlast  = (cnt_r == cenc_pkg::LAST_WORD);

  // Configuration registers.
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cenc_pkg::reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r[0] <= cenc_pkg::POLY0_RST;
      poly_r[1] <= cenc_pkg::POLY1_RST;
      poly_r[2] <= cenc_pkg::POLY2_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        cenc_pkg::REG_POLY0: poly_r[0] <= cfg_pwdata[cenc_pkg::POLY_W-1:0];
        cenc_pkg::REG_POLY1: poly_r[1] <= cfg_pwdata[cenc_pkg::POLY_W-1:0];
        cenc_pkg::REG_POLY2: poly_r[2] <= cfg_pwdata[cenc_pkg::POLY_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (cfg_idx)
      cenc_pkg::REG_POLY0: cfg_prdata = cenc_pkg::APB_DW'(poly_r[0]);
      cenc_pkg::REG_POLY1: cfg_prdata = cenc_pkg::APB_DW'(poly_r[1]);
      cenc_pkg::REG_POLY2: cfg_prdata = cenc_pkg::APB_DW'(poly_r[2]);
      default:             cfg_prdata = '0;
    endcase
  end

  // A word count past zero only exists while results are held.
  a_cnt_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) |-> res_valid_r)
    else $error("word count nonzero with empty result stage");

  // A held item must not advance while earlier code words are still pending.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && res_valid_r && !out_done) |-> !in_tready)
    else $error("input stage advanced over pending code words");

  // Loading an item starts its first code word.
  a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (res_valid_r && cnt_r == '0))
    else $error("result stage not started after load");

  // The final beat with nothing waiting empties the result stage.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_done && !in_valid_r) |=> !res_valid_r)
    else $error("result stage still valid after final beat");

endmodule

>>> dv/tb.sv
// Self-checking testbench for the word-packed rate 1/N convolutional encoder.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES  = 80;    // long receiver hold-off that backs up the pipe
  localparam int IDLE_PCT     = 18;    // percent of cycles each side idles
  localparam int STALL_LIMIT  = 2000;  // cycles without any beat before giving up
  localparam int DRAIN_CYCLES = 10;    // quiet cycles after the last code word
  localparam int RAND_PHASES  = 4;
  localparam int RAND_ITEMS   = 103;   // data beats per random phase

  // Register index past the end of the map; writes there must be dropped.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // History mask: only the last CONSTRAINT_LENGTH message bits take part.
  localparam cenc_pkg::poly_t HIST_MASK =
    cenc_pkg::poly_t'((1 << cenc_pkg::CONSTRAINT_LENGTH) - 1);

  typedef struct packed {
    logic [cenc_pkg::WORD_BITS-1:0] code;
    logic                           last;
  } code_beat_t;

  typedef enum logic {ROW_DATA, ROW_WRITE} row_kind_t;

  // One row of directed stimulus: a data beat or a register write.
  // A data row with known set expects every code word to equal fill.
  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  reg_idx;
    logic [31:0] value;
    logic        restart;
    logic        known;
    logic [15:0] fill;
  } stim_row_t;

  localparam int NUM_ROWS = 34;
  localparam stim_row_t DIRECTED [NUM_ROWS] = '{
    // Reset generators: zero history and zero data give all-zero code words.
    '{ROW_DATA,  cenc_pkg::REG_POLY0, 32'h0000_0000, 1'b1, 1'b1, 16'h0000},
    '{ROW_DATA,  cenc_pkg::REG_POLY0, 32'h0000_FFFF, 1'b0, 1'b0, 16'h0000},
    '{ROW_DATA,  cenc_pkg::REG_POLY0, 32'h0000_0001, 1'b0, 1'b0, 16'h0000},
    '{ROW_DATA,  cenc_pkg::REG_POLY0, 32'h0000_8000, 1'b0, 1'b0, 16'h0000},
    '{ROW_DATA,  cenc_pkg::REG_POLY0, 32'h0000_A5A5, 1'b1, 1'b0, 16'h0000},
    '{ROW_DATA,  cenc_pkg::REG_POLY0, 32'h0000_5A5A, 1'b0, 1'b0, 16'h0000},
    // Tap only the newest bit: every code bit copies its message bit.
    // A write past the register map must change nothing.
    '{ROW_WRITE, cenc_pkg::REG_POLY0, 32'h0000_0001, 1'b0, 1'b0, 16'h0000},
    '{ROW_WRITE, cenc_pkg::REG_POLY1, 32'h0000_0001, 1'b0, 1'b0, 16'h0000},
    '{ROW_WRITE, cenc_pkg::REG_POLY2, 32'h0000_0001, 1'b0, 1'b0, 16'h0000},
    '{ROW_WRITE, REG_UNUSED,          32'h0000_7FFF, 1'b0, 1'b0, 16'h0000},
    '{ROW_DATA,  cenc_pkg::REG_POLY0, 32'h0000_FFFF, 1'b1, 1'b1, 16'hFFFF},
    '{ROW_DATA,  cenc_pkg::REG_POLY0, 32'h0000_0000, 1'b1, 1'b1, 16'h0000},
    '{ROW_DATA,  cenc_pkg::REG_POLY0, 32'h0000_1234, 1'b0, 1'b0, 16'h0000},
    // All generator bits set: taps at or above the constraint length are ignored.
    '{ROW_WRITE, cenc_pkg::REG_POLY0, 32'h0000_7FFF, 1'b0, 1'b0, 16'h0000},
    '{ROW_WRITE, cenc_pkg::REG_POLY1, 32'h0000_7FFF, 1'b0, 1'b0, 16'h0000},
    '{ROW_WRITE, cenc_pkg::REG_POLY2, 32'h0000_7FFF, 1'b0, 1'b0, 16'h0000},
    '{ROW_DATA,  cenc_pkg::REG_POLY0, 32'h0000_FFFF, 1'b1, 1'b0, 16'h0000},
    '{ROW_DATA,  cenc_pkg::REG_POLY0, 32'h0000_0000, 1'b0, 1'b0, 16'h0000},
    '{ROW_DATA,  cenc_pkg::REG_POLY0, 32'h0000_8001, 1'b1, 1'b0, 16'h0000},
    // No taps at all: the code stream is all zeros whatever the data.
    '{ROW_WRITE, cenc_pkg::REG_POLY0, 32'h0000_0000, 1'b0, 1'b0, 16'h0000},
    '{ROW_WRITE, cenc_pkg::REG_POLY1, 32'h0000_0000, 1'b0, 1'b0, 16'h0000},
    '{ROW_WRITE, cenc_pkg::REG_POLY2, 32'h0000_0000, 1'b0, 1'b0, 16'h0000},
    '{ROW_DATA,  cenc_pkg::REG_POLY0, 32'h0000_FFFF, 1'b0, 1'b1, 16'h0000},
    '{ROW_DATA,  cenc_pkg::REG_POLY0, 32'h0000_3C3C, 1'b1, 1'b1, 16'h0000},
    // Odd third generator, which only matters with three code bits per message bit.
    '{ROW_WRITE, cenc_pkg::REG_POLY0, 32'h0000_000D, 1'b0, 1'b0, 16'h0000},
    '{ROW_WRITE, cenc_pkg::REG_POLY1, 32'h0000_007A, 1'b0, 1'b0, 16'h0000},
    '{ROW_WRITE, cenc_pkg::REG_POLY2, 32'h0000_2A55, 1'b0, 1'b0, 16'h0000},
    '{ROW_DATA,  cenc_pkg::REG_POLY0, 32'h0000_BEEF, 1'b1, 1'b0, 16'h0000},
    '{ROW_DATA,  cenc_pkg::REG_POLY0, 32'h0000_0F0F, 1'b0, 1'b0, 16'h0000},
    // Back to the reset generators.
    '{ROW_WRITE, cenc_pkg::REG_POLY0, 32'h0000_003D, 1'b0, 1'b0, 16'h0000},
    '{ROW_WRITE, cenc_pkg::REG_POLY1, 32'h0000_004F, 1'b0, 1'b0, 16'h0000},
    '{ROW_WRITE, cenc_pkg::REG_POLY2, 32'h0000_006D, 1'b0, 1'b0, 16'h0000},
    '{ROW_DATA,  cenc_pkg::REG_POLY0, 32'h0000_0000, 1'b1, 1'b1, 16'h0000},
    '{ROW_DATA,  cenc_pkg::REG_POLY0, 32'h0000_FFFF, 1'b0, 1'b0, 16'h0000}
  };

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_tvalid;
  logic                          in_tready;
  logic [15:0]                   in_tdata;     // [15:0] data_word
  logic                          in_tuser;     // [0] restart
  logic                          out_tvalid;
  logic                          out_tready;
  logic [15:0]                   out_tdata;    // [15:0] code_word
  logic                          out_tlast;    // last_of_word
  logic                          cfg_psel;
  logic                          cfg_penable;
  logic                          cfg_pwrite;
  logic [cenc_pkg::APB_AW-1:0]   cfg_paddr;
  logic [cenc_pkg::APB_DW-1:0]   cfg_pwdata;
  logic [cenc_pkg::APB_DW-1:0]   cfg_prdata;
  logic                          cfg_pready;

  // Predictor state: generator copy and message history.
  cenc_pkg::poly_t gen_poly [cenc_pkg::NUM_POLY] =
    '{cenc_pkg::POLY0_RST, cenc_pkg::POLY1_RST, cenc_pkg::POLY2_RST};
  cenc_pkg::poly_t msg_history = '0;
  code_beat_t      pending_code_words[$];

  int mismatches = 0;
  int stall_cycles = 0;
  logic quiet = 1'b0;      // no idling on either side while set
  logic hold_req = 1'b0;   // asks the receiver for its long hold-off
  logic hold_done = 1'b0;

  convolutional_encoder_word_packed_top i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #6 clk = ~clk;

  // Encode one data word, bit 0 first, and return the packed code stream.
  function automatic logic [cenc_pkg::STREAM_W-1:0] encode_word(
    logic [cenc_pkg::WORD_BITS-1:0] data, logic restart);
    logic [cenc_pkg::STREAM_W-1:0] stream;
    int pos;
    int i;
    int c;
    stream = '0;
    pos = 0;
    if (restart) begin
      msg_history = '0;
    end
    for (i = 0; i < cenc_pkg::WORD_BITS; i++) begin
      msg_history = ((msg_history << 1) | cenc_pkg::poly_t'(data[i])) & HIST_MASK;
      for (c = 0; c < cenc_pkg::OUTPUTS_PER_BIT; c++) begin
        stream[pos] = ^(msg_history & gen_poly[c]);
        pos++;
      end
    end
    return stream;
  endfunction

  // Offer one data beat, with random gaps, and queue its code words once taken.
  task automatic send_word(logic [15:0] data, logic restart, logic known,
                           logic [15:0] fill);
    logic [cenc_pkg::STREAM_W-1:0] stream;
    int c;
    @(negedge clk);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= restart;
    do @(posedge clk); while (!in_tready);
    stream = encode_word(data, restart);
    for (c = 0; c < cenc_pkg::OUTPUTS_PER_BIT; c++) begin
      pending_code_words.push_back(code_beat_t'{
        known ? fill : stream[c*cenc_pkg::WORD_BITS +: cenc_pkg::WORD_BITS],
        c == cenc_pkg::OUTPUTS_PER_BIT - 1});
    end
  endtask

  // Write one register once every queued code word has come out.
  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_code_words.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (idx < cenc_pkg::NUM_POLY) begin
      gen_poly[idx] = value[cenc_pkg::POLY_W-1:0];
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Receiver: random back-pressure, one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        out_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Compare each code word beat with the oldest expectation.
  always @(posedge clk) begin : check_code_words
    code_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_code_words.size() == 0) begin
        $error("code_word 0x%h arrived with no expectation", out_tdata);
        mismatches++;
      end else begin
        want = pending_code_words.pop_front();
        if (out_tdata !== want.code) begin
          $error("code_word: expected 0x%h, actual 0x%h", want.code, out_tdata);
          mismatches++;
        end
        if (out_tlast !== want.last) begin
          $error("last_of_word: expected %0b, actual %0b", want.last, out_tlast);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles in which no beat moves on any port.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Stimulus: directed table, then random phases with fresh generators.
  initial begin
    int r;
    int p;
    int n;
    int k;
    logic [31:0] poly_val;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = 1'b0;
    out_tready  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (r = 0; r < NUM_ROWS; r++) begin
      if (DIRECTED[r].kind == ROW_WRITE) begin
        write_reg(DIRECTED[r].reg_idx, DIRECTED[r].value);
      end else begin
        send_word(DIRECTED[r].value[15:0], DIRECTED[r].restart, DIRECTED[r].known,
                  DIRECTED[r].fill);
      end
    end

    for (p = 0; p < RAND_PHASES; p++) begin
      // Generators: mostly random 32-bit writes, sometimes the extremes.
      for (k = 0; k < cenc_pkg::NUM_POLY; k++) begin
        case ($urandom_range(7))
          0:       poly_val = 32'h0000_0000;
          1:       poly_val = 32'h0000_7FFF;
          default: poly_val = $urandom();
        endcase
        write_reg(k[1:0], poly_val);
      end
      write_reg(REG_UNUSED, $urandom());
      hold_req = (p == 1);
      quiet    = (p == 2);
      for (n = 0; n < RAND_ITEMS; n++) begin
        send_word(16'($urandom_range(65535)), $urandom_range(7) == 0, 1'b0, 16'h0000);
      end
    end

    // Let the last code words out, then a short quiet tail.
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_code_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/cenc_pkg.sv
rtl/convolutional_encoder_word_packed_top.sv
dv/tb.sv
